@@ sv/rse_pkg.sv @@
// Package for the Reed-Solomon parity encoder: beat types and GF(256) helpers.
// No dependencies; every other file in the folder refers to it by scoped names.
package rse_pkg;

    localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;
    localparam logic [7:0] ALPHA          = 8'h02;
    localparam logic [5:0] RESET_LEN      = 6'd10;
    localparam int         CFG_W          = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       parity_last;
    } t_out_beat;

    // Multiplication in GF(256) modulo x^8 + x^4 + x^3 + x^2 + 1.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY_LOW : 8'h00);
            if (b[i]) begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

endpackage

@@ sv/rse_gen.sv @@
// Generator polynomial unit: multiplies in one root (x - 2^i) per cycle.
// Depends on rse_pkg for the GF(256) multiplier.
module rse_gen #(
    parameter int MAX_PARITY_LEN = 32,
    parameter int LW             = $clog2(MAX_PARITY_LEN + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [LW-1:0]                  i_len,
    input  logic [LW-1:0]                  i_reset_len,
    output logic [MAX_PARITY_LEN-1:0][7:0] o_coeffs,
    output logic [LW-1:0]                  o_len,
    output logic                           o_busy
);

    logic [MAX_PARITY_LEN-1:0][7:0] r_coef, n_coef;
    logic [MAX_PARITY_LEN-1:0][7:0] w_init;
    logic [7:0]                     r_root;
    logic [LW-1:0]                  r_cnt;
    logic [LW-1:0]                  r_len;
    logic [LW-1:0]                  w_init_len;
    logic                           r_busy;

    assign w_init_len = i_rst_n ? i_len : i_reset_len;

    always_comb begin
        for (int j = 0; j < MAX_PARITY_LEN; j++) begin
            w_init[j] = (LW'(j + 1) == w_init_len) ? 8'h01 : 8'h00;
        end
        for (int j = 0; j < MAX_PARITY_LEN - 1; j++) begin
            n_coef[j] = rse_pkg::gf_mul(r_coef[j], r_root) ^ r_coef[j + 1];
        end
        n_coef[MAX_PARITY_LEN - 1] = rse_pkg::gf_mul(r_coef[MAX_PARITY_LEN - 1], r_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_coef <= w_init;
            r_root <= 8'h01;
            r_cnt  <= '0;
            r_len  <= w_init_len;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_coef <= n_coef;
            r_root <= rse_pkg::gf_mul(r_root, rse_pkg::ALPHA);
            r_cnt  <= r_cnt + LW'(1);
            if (r_cnt == r_len - LW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_coeffs = r_coef;
    assign o_len    = r_len;
    assign o_busy   = r_busy;

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < r_len))
        else $error("generator step count reached the length while busy");

endmodule

@@ sv/rse_core.sv @@
// Byte datapath: input register, LFSR remainder update, parity output buffer.
// Depends on rse_pkg for beat types and the GF(256) multiplier.
module rse_core #(
    parameter int MAX_PARITY_LEN = 32,
    parameter int LW             = $clog2(MAX_PARITY_LEN + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_hold,
    input  logic [MAX_PARITY_LEN-1:0][7:0] i_coeffs,
    input  logic [LW-1:0]                  i_len,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rse_pkg::t_in_beat              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rse_pkg::t_out_beat             o_out
);

    rse_pkg::t_in_beat              r_in;
    logic                           r_in_valid;
    logic [MAX_PARITY_LEN-1:0][7:0] r_rem, n_rem;
    logic [MAX_PARITY_LEN-1:0][7:0] r_par;
    logic [LW-1:0]                  r_cnt;
    logic [7:0]                     w_factor;
    logic                           w_buf_free;
    logic                           w_fire;
    logic                           w_load;
    logic                           w_out_take;

    assign w_out_take = (r_cnt != '0) && i_out_ready;
    assign w_buf_free = (r_cnt == '0) || ((r_cnt == LW'(1)) && i_out_ready);
    assign w_fire     = r_in_valid && (!r_in.block_end || w_buf_free);
    assign w_load     = w_fire && r_in.block_end;
    assign o_in_ready = !i_hold && (!r_in_valid || w_fire);
    assign w_factor   = r_in.data_byte ^ r_rem[0];

    always_comb begin
        for (int j = 0; j < MAX_PARITY_LEN - 1; j++) begin
            n_rem[j] = r_rem[j + 1] ^ rse_pkg::gf_mul(i_coeffs[j], w_factor);
        end
        n_rem[MAX_PARITY_LEN - 1] = rse_pkg::gf_mul(i_coeffs[MAX_PARITY_LEN - 1], w_factor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_rem <= '0;
        end else if (w_fire) begin
            r_rem <= r_in.block_end ? '0 : n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= i_len;
        end else if (w_out_take) begin
            r_cnt <= r_cnt - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_par <= n_rem;
        end else if (w_out_take) begin
            for (int j = 0; j < MAX_PARITY_LEN - 1; j++) begin
                r_par[j] <= r_par[j + 1];
            end
            r_par[MAX_PARITY_LEN - 1] <= 8'h00;
        end
    end

    assign o_out_valid       = r_cnt != '0;
    assign o_out.parity_byte = r_par[0];
    assign o_out.parity_last = r_cnt == LW'(1);

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= i_len)
        else $error("parity count exceeds the parity length");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_buf_free)
        else $error("parity buffer reloaded before it drained");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out.parity_last && !w_load) |=> !o_out_valid)
        else $error("output still valid after the final parity beat");

endmodule

@@ sv/reed_solomon_ecc_encoder_unit.sv @@
// Top level of the systematic Reed-Solomon encoder over GF(256), polynomial 0x11D.
// A block_end byte is registered, then its parity loads into the output buffer once that
// buffer is free; the first parity beat then leaves from that buffer.
// Throughput: one data byte per cycle outside a derivation; parity bytes leave one per
// cycle from a buffer while the output is ready; a block shorter than the parity length
// waits for it to drain. Reset and every length write run a generator derivation.
module reed_solomon_ecc_encoder_unit #(
    parameter int MAX_PARITY_LEN = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rse_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rse_pkg::t_out_beat o_out
);

    localparam int LW = $clog2(MAX_PARITY_LEN + 1);
    localparam int CW = (LW > rse_pkg::CFG_W) ? LW : rse_pkg::CFG_W;

    logic [MAX_PARITY_LEN-1:0][7:0] w_coeffs;
    logic [LW-1:0]                  w_len;
    logic [LW-1:0]                  w_cfg_len;
    logic [LW-1:0]                  w_reset_len;
    logic                           w_busy;
    logic                           w_cfg_take;

    function automatic logic [LW-1:0] clamp_len(input logic [5:0] value);
        logic [CW-1:0] v;
        v = CW'(value);
        if (v < CW'(2)) begin
            return LW'(2);
        end else if (v > CW'(MAX_PARITY_LEN)) begin
            return LW'(MAX_PARITY_LEN);
        end
        return LW'(v);
    endfunction

    assign w_cfg_len   = clamp_len(i_cfg_data);
    assign w_reset_len = clamp_len(rse_pkg::RESET_LEN);
    assign o_cfg_ready = !w_busy;
    assign w_cfg_take  = i_cfg_valid && o_cfg_ready;

    rse_gen #(
        .MAX_PARITY_LEN(MAX_PARITY_LEN),
        .LW            (LW)
    ) u_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cfg_take),
        .i_len      (w_cfg_len),
        .i_reset_len(w_reset_len),
        .o_coeffs   (w_coeffs),
        .o_len      (w_len),
        .o_busy     (w_busy)
    );

    rse_core #(
        .MAX_PARITY_LEN(MAX_PARITY_LEN),
        .LW            (LW)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_cfg_take),
        .i_hold     (w_busy),
        .i_coeffs   (w_coeffs),
        .i_len      (w_len),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

@@ test/rse_parity_checker.sv @@
// Checker for the Reed-Solomon parity encoder: it watches the length, data and parity channels,
// keeps its own GF(256) remainder and generator, and compares every parity beat in order.
// Depends on rse_pkg for the beat types and the field constants.
module rse_parity_checker #(
    parameter int MAX_LEN = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rse_pkg::t_in_beat  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rse_pkg::t_out_beat i_out,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] gen_coef [MAX_LEN];
    logic [7:0] lfsr [MAX_LEN];
    int unsigned parity_len;
    rse_pkg::t_out_beat parity_expected [$];
    int mismatch_cnt = 0;

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] x;
        logic [7:0] y;
        prod = 8'h00;
        x = a;
        y = b;
        for (int k = 0; k < 8; k++) begin
            if (y[0]) begin
                prod = prod ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? rse_pkg::FIELD_POLY_LOW : 8'h00);
            y = y >> 1;
        end
        return prod;
    endfunction

    function automatic void set_parity_length(input logic [5:0] value);
        logic [7:0] root;
        logic [7:0] term;
        if (value < 2) begin
            parity_len = 2;
        end else if (value > MAX_LEN) begin
            parity_len = MAX_LEN;
        end else begin
            parity_len = 32'(value);
        end
        for (int i = 0; i < MAX_LEN; i++) begin
            gen_coef[i] = 8'h00;
            lfsr[i] = 8'h00;
        end
        gen_coef[parity_len - 1] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < parity_len; i++) begin
            for (int j = 0; j < parity_len; j++) begin
                term = gf_times(gen_coef[j], root);
                if (j + 1 < parity_len) begin
                    term = term ^ gen_coef[j + 1];
                end
                gen_coef[j] = term;
            end
            root = gf_times(root, rse_pkg::ALPHA);
        end
    endfunction

    function automatic void absorb_byte(input rse_pkg::t_in_beat b);
        logic [7:0] factor;
        rse_pkg::t_out_beat beat;
        factor = b.data_byte ^ lfsr[0];
        for (int j = 0; j + 1 < parity_len; j++) begin
            lfsr[j] = lfsr[j + 1];
        end
        lfsr[parity_len - 1] = 8'h00;
        for (int j = 0; j < parity_len; j++) begin
            lfsr[j] = lfsr[j] ^ gf_times(gen_coef[j], factor);
        end
        if (b.block_end) begin
            for (int j = 0; j < parity_len; j++) begin
                beat.parity_byte = lfsr[j];
                beat.parity_last = (j == parity_len - 1);
                parity_expected = {parity_expected, beat};
                lfsr[j] = 8'h00;
            end
        end
    endfunction

    function automatic void record_failure(input string what, input rse_pkg::t_out_beat want,
                                           input rse_pkg::t_out_beat got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b", $realtime,
                     what, want.parity_byte, want.parity_last, got.parity_byte, got.parity_last);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        rse_pkg::t_out_beat want;
        if (!i_rst_n) begin
            set_parity_length(rse_pkg::RESET_LEN);
            parity_expected.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (parity_expected.size() == 0) begin
                    record_failure("unexpected parity beat", '0, i_out);
                end else begin
                    want = parity_expected.pop_front();
                    if (want.parity_byte !== i_out.parity_byte
                            || want.parity_last !== i_out.parity_last) begin
                        record_failure("parity beat mismatch", want, i_out);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                set_parity_length(i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                absorb_byte(i_in);
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending <= parity_expected.size();
    end

endmodule

@@ test/reed_solomon_ecc_encoder_unit_tb.sv @@
// Testbench top for the Reed-Solomon parity encoder: drives length writes and data beats
// under several flow-control patterns and gives the verdict.
// Depends on rse_pkg, reed_solomon_ecc_encoder_unit and rse_parity_checker.
module reed_solomon_ecc_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_BYTES  = 80;

    typedef enum int {
        PH_DIRECTED,
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE,
        PH_BACKPRESSURE
    } t_phase;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [5:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    rse_pkg::t_in_beat  i_in = '0;
    logic               i_out_ready = 1'b0;
    logic               o_cfg_ready;
    logic               o_in_ready;
    logic               o_out_valid;
    rse_pkg::t_out_beat o_out;

    int     fail_count;
    int     pending;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    t_phase phase = PH_DIRECTED;
    int     quiet_cycles = 0;
    int     hold_cnt = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    reed_solomon_ecc_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    rse_parity_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // In the backpressure phase the output is held off long enough for the encoder to fill up.
    always @(posedge i_clk) begin
        if (phase == PH_BACKPRESSURE && hold_cnt < HOLD_CYCLES) begin
            hold_cnt++;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{data_byte: value, block_end: last};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_block(input int n);
        for (int k = 0; k < n; k++) begin
            send_byte(8'($urandom_range(255)), k == n - 1);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [5:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input t_phase ph, input int idle_pct, input int stall_pct,
                             input logic [5:0] len, input int max_block);
        int sent;
        int n;
        write_length(len);
        phase = ph;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_BYTES) begin
            if ($urandom_range(7) == 0) begin
                n = $urandom_range(40, 7);
            end else begin
                n = $urandom_range(max_block, 1);
            end
            send_block(n);
            sent += n;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        // This partial block is thrown away by the length write that follows.
        send_byte(8'h01, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hA5, 1'b0);
        write_length(6'd1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        write_length(6'd0);
        send_byte(8'hC3, 1'b1);
        write_length(6'd63);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        write_length(6'd33);
        send_byte(8'h12, 1'b1);
        write_length(6'd32);
        send_byte(8'hFF, 1'b1);
        write_length(6'd2);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        run_phase(PH_STEADY, 0, 0, 6'd10, 6);
        run_phase(PH_SEND_IDLE, 51, 0, 6'($urandom_range(31, 3)), 6);
        run_phase(PH_RECV_STALL, 0, 51, 6'd32, 6);
        run_phase(PH_BOTH_IDLE, 12, 12, 6'($urandom_range(63)), 6);
        run_phase(PH_BACKPRESSURE, 0, 0, 6'd32, 3);

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/rse_pkg.sv
sv/rse_gen.sv
sv/rse_core.sv
sv/reed_solomon_ecc_encoder_unit.sv
test/rse_parity_checker.sv
test/reed_solomon_ecc_encoder_unit_tb.sv
